/* design/assert_macros.svh */
// Assertion macros used by the checker file of the pair substitution unit.
// Needs nothing but the clock and reset names passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define PFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define PFS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pfs_pkg.sv */
// Shared types, constants and helper functions of the pair substitution unit.
// Has no dependencies; every design module imports it.
package pfs_pkg;

    localparam int GRID_SIDE = 5;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int LETTERS   = 26;
    localparam int LW        = 5;                  // letter width
    localparam int CW        = $clog2(CELLS);      // cell index width
    localparam int RW        = $clog2(GRID_SIDE);  // row and column width

    typedef enum logic [1:0] {
        CMD_KEY  = 2'd0,
        CMD_SEAL = 2'd1,
        CMD_PAIR = 2'd2,
        CMD_LONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PASS      = 2'd1,
        ST_DROP      = 2'd2,
        ST_NOTSEALED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOOK = 2'd1,
        S_GRID = 2'd2,
        S_SEAL = 2'd3
    } t_state;

    // One write into the grid and into every copy of the position table.
    typedef struct packed {
        logic          en;
        logic [LW-1:0] letter;
        logic [CW-1:0] slot;
    } t_wr;

    // Row and column of one letter, as found by a lane.
    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] col;
    } t_lane;

    // Splits a cell index below 25 into row and column. The row is the index
    // times 13/64, which equals the index divided by five over that range.
    function automatic t_lane pos_split(input logic [CW-1:0] p);
        logic [9:0]    prod;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        t_lane         res;
        prod    = 10'(p) * 10'd13;
        row     = prod[8:6];
        col     = p - CW'(CW'(row) * CW'(GRID_SIDE));
        res.row = row;
        res.col = col[RW-1:0];
        return res;
    endfunction

    function automatic logic [CW-1:0] cell_index(input logic [RW-1:0] row,
                                                 input logic [RW-1:0] col);
        return CW'(CW'(row) * CW'(GRID_SIDE)) + CW'(col);
    endfunction

endpackage

/* design/playfair_pair_substitution_unit.sv */
// Playfair pair substitution unit. Key letters (a=0 .. z=25) fill a 5x5 grid
// one transaction at a time; a seal command walks all 26 letters, one per
// cycle, placing the unused ones in alphabetical order, and the one left over
// becomes the excluded letter. Every input transaction yields exactly one
// result transaction. Key letters, lone letters, seals of a sealed grid and
// pairs that pass unchanged are finished in the cycle they are taken. A
// substituted pair goes through a position lookup in two parallel lanes,
// then a two-port grid read. A seal of an open grid keeps the unit busy for
// the letter walk. A finished result waits in a pending register and then
// in the output register, so one more transaction can be finished while the
// output side is stalled. The input is stalled while the unit is busy or
// while the pending register holds a result.
module playfair_pair_substitution_unit import pfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_command,
    input  logic [LW-1:0] i_first_letter,
    input  logic [LW-1:0] i_second_letter,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [LW-1:0] o_first_out,
    output logic [LW-1:0] o_second_out,
    output logic [1:0]    o_letter_count,
    output logic [1:0]    o_status
);

    // Control state.
    t_state              r_state, n_state;
    logic [LETTERS-1:0]  r_placed, n_placed;
    logic [CW-1:0]       r_fill, n_fill;
    logic                r_sealed, n_sealed;
    logic [LW-1:0]       r_excl, n_excl;
    logic [LW-1:0]       r_seal_idx, n_seal_idx;

    // The letters of the transaction in flight.
    logic [LW-1:0]       r_a, r_b;

    // Pending result and output register.
    logic                r_pend_valid;
    logic [LW-1:0]       r_pend_first, r_pend_second;
    logic [1:0]          r_pend_count;
    t_status             r_pend_status;
    logic                pend_load;
    logic [LW-1:0]       n_pend_first, n_pend_second;
    logic [1:0]          n_pend_count;
    t_status             n_pend_status;

    logic                r_out_valid;
    logic [LW-1:0]       r_out_first, r_out_second;
    logic [1:0]          r_out_count;
    t_status             r_out_status;

    t_cmd                cmd;
    logic                in_acc;
    logic                out_free;
    logic                pair_pass;
    logic                a_ok;
    logic [LETTERS-1:0]  placed_base;
    logic [CW-1:0]       fill_base;
    t_wr                 wr;
    t_lane               lane_a, lane_b;
    logic                swap;
    logic [LW-1:0]       cell_a, cell_b;

    assign cmd      = t_cmd'(i_command);
    assign o_stall  = (r_state != S_IDLE) || r_pend_valid;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign a_ok     = i_first_letter < LW'(LETTERS);

    // A pair passes unchanged when it holds an invalid letter, the excluded
    // letter, or the same letter twice.
    assign pair_pass = !a_ok || (i_second_letter >= LW'(LETTERS)) ||
                       (i_first_letter == r_excl) || (i_second_letter == r_excl) ||
                       (i_first_letter == i_second_letter);

    // A key letter after sealing starts over from an empty grid.
    assign placed_base = r_sealed ? '0 : r_placed;
    assign fill_base   = r_sealed ? '0 : r_fill;

    // Two lanes look up the positions of both letters side by side.
    pfs_lane u_lane_a (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_letter (i_first_letter),
        .o_pos    (lane_a)
    );

    pfs_lane u_lane_b (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_letter (i_second_letter),
        .o_pos    (lane_b)
    );

    pfs_merge u_merge (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_lane_a (lane_a),
        .i_lane_b (lane_b),
        .o_swap   (swap),
        .o_cell_a (cell_a),
        .o_cell_b (cell_b)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        CMD_KEY:  n_state = S_IDLE;
                        CMD_SEAL: n_state = r_sealed ? S_IDLE : S_SEAL;
                        CMD_PAIR: n_state = (r_sealed && !pair_pass) ? S_LOOK : S_IDLE;
                        CMD_LONE: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: n_state = S_GRID;
            S_GRID: n_state = S_IDLE;
            S_SEAL: n_state = (r_seal_idx == LW'(LETTERS - 1)) ? S_IDLE : S_SEAL;
        endcase
    end

    // Table updates and results.
    always_comb begin
        n_placed      = r_placed;
        n_fill        = r_fill;
        n_sealed      = r_sealed;
        n_excl        = r_excl;
        n_seal_idx    = r_seal_idx;
        wr            = '0;
        pend_load     = 1'b0;
        n_pend_first  = '0;
        n_pend_second = '0;
        n_pend_count  = 2'd0;
        n_pend_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        CMD_KEY: begin
                            pend_load = 1'b1;
                            n_sealed  = 1'b0;
                            n_placed  = placed_base;
                            n_fill    = fill_base;
                            if (!a_ok || placed_base[i_first_letter] ||
                                (fill_base >= CW'(CELLS))) begin
                                n_pend_status = ST_DROP;
                            end else begin
                                wr.en     = 1'b1;
                                wr.letter = i_first_letter;
                                wr.slot   = fill_base;
                                n_placed[i_first_letter] = 1'b1;
                                n_fill    = fill_base + CW'(1);
                            end
                        end
                        CMD_SEAL: begin
                            if (r_sealed) begin
                                pend_load = 1'b1;
                            end else begin
                                n_seal_idx = '0;
                            end
                        end
                        CMD_PAIR: begin
                            if (!r_sealed) begin
                                pend_load     = 1'b1;
                                n_pend_status = ST_NOTSEALED;
                            end else if (pair_pass) begin
                                pend_load     = 1'b1;
                                n_pend_first  = i_first_letter;
                                n_pend_second = i_second_letter;
                                n_pend_count  = 2'd2;
                                n_pend_status = ST_PASS;
                            end
                        end
                        CMD_LONE: begin
                            pend_load     = 1'b1;
                            n_pend_first  = i_first_letter;
                            n_pend_count  = 2'd1;
                            n_pend_status = ST_PASS;
                        end
                    endcase
                end
            end
            S_LOOK: begin
            end
            S_GRID: begin
                pend_load     = 1'b1;
                n_pend_first  = swap ? r_b : cell_a;
                n_pend_second = swap ? r_a : cell_b;
                n_pend_count  = 2'd2;
                n_pend_status = ST_OK;
            end
            S_SEAL: begin
                if (!r_placed[r_seal_idx]) begin
                    if (r_fill < CW'(CELLS)) begin
                        wr.en     = 1'b1;
                        wr.letter = r_seal_idx;
                        wr.slot   = r_fill;
                        n_placed[r_seal_idx] = 1'b1;
                        n_fill    = r_fill + CW'(1);
                    end else begin
                        // Exactly one letter finds no free cell.
                        n_excl = r_seal_idx;
                    end
                end
                n_seal_idx = r_seal_idx + LW'(1);
                if (r_seal_idx == LW'(LETTERS - 1)) begin
                    n_sealed  = 1'b1;
                    pend_load = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_placed     <= '0;
            r_fill       <= '0;
            r_sealed     <= 1'b0;
            r_excl       <= '0;
            r_seal_idx   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_placed   <= n_placed;
            r_fill     <= n_fill;
            r_sealed   <= n_sealed;
            r_excl     <= n_excl;
            r_seal_idx <= n_seal_idx;
            if (pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && out_free) begin
                r_pend_valid <= 1'b0;
            end
            if (r_pend_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= i_first_letter;
            r_b <= i_second_letter;
        end
        if (pend_load) begin
            r_pend_first  <= n_pend_first;
            r_pend_second <= n_pend_second;
            r_pend_count  <= n_pend_count;
            r_pend_status <= n_pend_status;
        end
        if (r_pend_valid && out_free) begin
            r_out_first  <= r_pend_first;
            r_out_second <= r_pend_second;
            r_out_count  <= r_pend_count;
            r_out_status <= r_pend_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_out    = r_out_first;
    assign o_second_out   = r_out_second;
    assign o_letter_count = r_out_count;
    assign o_status       = r_out_status;

endmodule

/* design/pfs_lane.sv */
// One lookup lane: a private copy of the letter position table and the
// split of the found cell index into row and column. Uses pfs_pkg.
module pfs_lane import pfs_pkg::*; (
    input  logic          i_clk,
    input  t_wr           i_wr,
    input  logic [LW-1:0] i_letter,
    output t_lane         o_pos
);

    logic [CW-1:0] r_pos_mem [LETTERS];
    logic [CW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pos_mem[i_wr.letter] <= i_wr.slot;
        end
        r_rd <= r_pos_mem[i_letter];
    end

    assign o_pos = pos_split(r_rd);

endmodule

/* design/pfs_merge.sv */
// Merging stage: compares the two lanes, forms the rectangle corner
// addresses and reads the letter grid at both. Uses pfs_pkg.
module pfs_merge import pfs_pkg::*; (
    input  logic          i_clk,
    input  t_wr           i_wr,
    input  t_lane         i_lane_a,
    input  t_lane         i_lane_b,
    output logic          o_swap,
    output logic [LW-1:0] o_cell_a,
    output logic [LW-1:0] o_cell_b
);

    logic [LW-1:0] r_grid_mem [CELLS];
    logic [CW-1:0] addr_a;
    logic [CW-1:0] addr_b;

    // Each letter moves to its own row and the partner's column.
    assign addr_a = cell_index(i_lane_a.row, i_lane_b.col);
    assign addr_b = cell_index(i_lane_b.row, i_lane_a.col);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_grid_mem[i_wr.slot] <= i_wr.letter;
        end
        o_cell_a <= r_grid_mem[addr_a];
        o_cell_b <= r_grid_mem[addr_b];
        o_swap   <= (i_lane_a.row == i_lane_b.row) || (i_lane_a.col == i_lane_b.col);
    end

endmodule

/* design/pfs_checker.sv */
// Port-level checker of the pair substitution unit and its bind statement.
// Uses pfs_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module pfs_checker import pfs_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [LW-1:0] o_first_out,
    input logic [LW-1:0] o_second_out,
    input logic [1:0]    o_letter_count,
    input logic [1:0]    o_status
);

    `PFS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_first_out) && $stable(o_second_out) && $stable(o_status), "stalled result changed")
    `PFS_ASSERT(a_no_letters, i_clk, i_rst_n, o_valid && (o_status == ST_DROP || o_status == ST_NOTSEALED) |-> o_letter_count == 2'd0 && o_first_out == '0 && o_second_out == '0, "dropped key or unsealed pair carries letters")
    `PFS_ASSERT(a_lone, i_clk, i_rst_n, o_valid && o_letter_count == 2'd1 |-> o_status == ST_PASS && o_second_out == '0, "lone letter result malformed")
    `PFS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "second transaction taken before the first was done")
    `PFS_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result shown after reset")

endmodule

bind playfair_pair_substitution_unit pfs_checker u_pfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_first_out    (o_first_out),
    .o_second_out   (o_second_out),
    .o_letter_count (o_letter_count),
    .o_status       (o_status)
);
